/* hdl/lzpd_pkg.sv */
// shared types, constants and helpers for the lz position-width decompressor
package lzpd_pkg;

  localparam int WINDOW_DEPTH_DEF = 16384;
  localparam int MAX_OFFSET_BITS  = 14;
  localparam int SIZE_W           = 24;
  localparam int LIT_BITS         = 8;
  localparam int UNARY_MAX        = 6;
  localparam int LEN_BASE         = 2;
  localparam logic [15:0] WIDE_POS = 16'h4000;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_PUSH  = 2'd1,
    OP_PULL  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_BYTE     = 3'd0,
    ST_NEED     = 3'd1,
    ST_DONE     = 3'd2,
    ST_PUSH_OK  = 3'd3,
    ST_PUSH_REJ = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_FLAG    = 3'd0,
    PH_LITERAL = 3'd1,
    PH_OFFSET  = 3'd2,
    PH_UNARY   = 3'd3,
    PH_ESCAPE  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    EV_CONT = 2'd0,
    EV_NEED = 2'd1,
    EV_LIT  = 2'd2,
    EV_COPY = 2'd3
  } bit_evt_t;

  typedef enum logic [1:0] {
    CS_IDLE  = 2'd0,
    CS_BIT   = 2'd1,
    CS_CP_RD = 2'd2,
    CS_CP_WR = 2'd3
  } ctrl_state_t;

  typedef struct packed {
    logic    start;
    logic    push;
    logic    bit_step;
    logic    copy_rd;
    logic    copy_wr;
    logic    out_load;
    status_t out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic     pos_done;
    logic     copy_pend;
    logic     size_zero;
    logic     push_busy;
    logic     out_free;
    bit_evt_t bit_evt;
  } dp_stat_t;

  // offset field width: msb index + 1 of the low position bits, capped
  function automatic logic [3:0] offset_width(input logic [15:0] pos16);
    logic [3:0] w;
    w = 4'd0;
    if (pos16 >= WIDE_POS) begin
      w = 4'(MAX_OFFSET_BITS);
    end else begin
      for (int i = 0; i < MAX_OFFSET_BITS; i++) begin
        if (pos16[i]) begin
          w = 4'(i + 1);
        end
      end
    end
    return w;
  endfunction

endpackage

/* hdl/lzpd_in_if.sv */
// input item channel: operation and compressed byte
interface lzpd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink (input valid, input operation, input data_byte, output ready);
endinterface

/* hdl/lzpd_out_if.sv */
// result item channel: decompressed byte and status
interface lzpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;

  modport source (output valid, output out_byte, output status, input ready);
  modport sink (input valid, input out_byte, input status, output ready);
endinterface

/* hdl/lzpd_dpath.sv */
// datapath: bit reader, token fields, history memory and result register
module lzpd_dpath #(
  parameter int WINDOW_DEPTH = lzpd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [lzpd_pkg::SIZE_W-1:0] cfg_wdata,
  input  logic [7:0]                 in_data_byte,
  input  lzpd_pkg::dp_cmd_t          cmd,
  output lzpd_pkg::dp_stat_t         stat,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_byte,
  output lzpd_pkg::status_t          out_status
);

  localparam int AW = $clog2(WINDOW_DEPTH);

  logic [lzpd_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic [lzpd_pkg::SIZE_W-1:0] pos_r, pos_nxt;
  logic [AW-1:0]               wptr_r, wptr_nxt;
  logic [7:0]                  bit_byte_r, bit_byte_nxt;
  logic [3:0]                  bits_left_r, bits_left_nxt;
  lzpd_pkg::phase_t            phase_r, phase_nxt;
  logic [13:0]                 acc_r, acc_nxt;
  logic [3:0]                  fbr_r, fbr_nxt;
  logic [13:0]                 moff_r, moff_nxt;
  logic [7:0]                  crem_r, crem_nxt;
  logic                        src_ok_r;
  logic [7:0]                  rdata_r;
  logic                        out_valid_r;
  logic [7:0]                  out_byte_r;
  lzpd_pkg::status_t           out_status_r;

  logic [7:0] mem [WINDOW_DEPTH];

  // one bit step
  logic               bl_ok;
  logic [3:0]         bl_m1;
  logic               cur_bit;
  logic [3:0]         fbr_inc;
  logic [7:0]         acc8;
  logic [13:0]        acc14;
  logic [3:0]         ow;
  lzpd_pkg::bit_evt_t evt;
  logic [3:0]         stp_bl;
  lzpd_pkg::phase_t   stp_phase;
  logic [13:0]        stp_acc;
  logic [3:0]         stp_fbr;
  logic [13:0]        stp_moff;
  logic [7:0]         stp_crem;

  // history access
  logic          mem_we;
  logic [7:0]    put_val;
  logic [AW:0]   rd_diff;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wptr_inc;

  assign ow      = lzpd_pkg::offset_width(pos_r[15:0]);
  assign bl_ok   = (bits_left_r != 4'd0) && (bits_left_r <= 4'd8);
  assign bl_m1   = bits_left_r - 4'd1;
  assign cur_bit = bit_byte_r[bl_m1[2:0]];
  assign fbr_inc = fbr_r + 4'd1;
  assign acc8    = {acc_r[6:0], cur_bit};
  assign acc14   = {acc_r[12:0], cur_bit};

  always_comb begin
    evt       = lzpd_pkg::EV_CONT;
    stp_bl    = bl_m1;
    stp_phase = phase_r;
    stp_acc   = acc_r;
    stp_fbr   = fbr_r;
    stp_moff  = moff_r;
    stp_crem  = crem_r;
    if (!bl_ok) begin
      evt    = lzpd_pkg::EV_NEED;
      stp_bl = 4'd0;
    end else begin
      case (phase_r)
        lzpd_pkg::PH_LITERAL, lzpd_pkg::PH_ESCAPE: begin
          stp_acc = 14'(acc8);
          stp_fbr = fbr_inc;
          if (fbr_inc >= 4'(lzpd_pkg::LIT_BITS)) begin
            stp_phase = lzpd_pkg::PH_FLAG;
            stp_acc   = '0;
            stp_fbr   = '0;
            if (phase_r == lzpd_pkg::PH_LITERAL) begin
              evt = lzpd_pkg::EV_LIT;
            end else begin
              stp_crem = acc8;
              if (acc8 != 8'd0) begin
                evt = lzpd_pkg::EV_COPY;
              end
            end
          end
        end
        lzpd_pkg::PH_OFFSET: begin
          stp_acc = acc14;
          stp_fbr = fbr_inc;
          if (fbr_inc >= ow) begin
            stp_moff  = acc14;
            stp_phase = lzpd_pkg::PH_UNARY;
            stp_acc   = '0;
            stp_fbr   = '0;
          end
        end
        lzpd_pkg::PH_UNARY: begin
          if (cur_bit) begin
            stp_crem  = {4'd0, fbr_r} + 8'(lzpd_pkg::LEN_BASE);
            stp_phase = lzpd_pkg::PH_FLAG;
            stp_acc   = '0;
            stp_fbr   = '0;
            evt       = lzpd_pkg::EV_COPY;
          end else begin
            stp_fbr = fbr_inc;
            if (fbr_inc >= 4'(lzpd_pkg::UNARY_MAX)) begin
              stp_phase = lzpd_pkg::PH_ESCAPE;
              stp_fbr   = '0;
              stp_acc   = '0;
            end
          end
        end
        default: begin
          stp_acc = '0;
          stp_fbr = '0;
          if (!cur_bit) begin
            stp_phase = lzpd_pkg::PH_LITERAL;
          end else if (ow == 4'd0) begin
            stp_moff  = '0;
            stp_phase = lzpd_pkg::PH_UNARY;
          end else begin
            stp_phase = lzpd_pkg::PH_OFFSET;
          end
        end
      endcase
    end
  end

  assign mem_we   = (cmd.bit_step && (evt == lzpd_pkg::EV_LIT)) || cmd.copy_wr;
  assign put_val  = cmd.copy_wr ? (src_ok_r ? rdata_r : 8'd0) : acc8;
  assign wptr_inc = (wptr_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wptr_r + AW'(1);
  assign rd_diff  = {1'b0, wptr_r} - (AW + 1)'(moff_r);
  assign rd_addr  = rd_diff[AW] ? AW'(rd_diff + (AW + 1)'(WINDOW_DEPTH)) : rd_diff[AW-1:0];

  always_comb begin
    size_nxt      = size_r;
    pos_nxt       = pos_r;
    wptr_nxt      = wptr_r;
    bit_byte_nxt  = bit_byte_r;
    bits_left_nxt = bits_left_r;
    phase_nxt     = phase_r;
    acc_nxt       = acc_r;
    fbr_nxt       = fbr_r;
    moff_nxt      = moff_r;
    crem_nxt      = crem_r;
    if (cfg_we) begin
      size_nxt = cfg_wdata;
    end
    if (cmd.start) begin
      pos_nxt       = '0;
      wptr_nxt      = '0;
      bit_byte_nxt  = '0;
      bits_left_nxt = '0;
      phase_nxt     = lzpd_pkg::PH_FLAG;
      acc_nxt       = '0;
      fbr_nxt       = '0;
      moff_nxt      = '0;
      crem_nxt      = '0;
    end
    if (cmd.push) begin
      bit_byte_nxt  = in_data_byte;
      bits_left_nxt = 4'd8;
    end
    if (cmd.bit_step) begin
      bits_left_nxt = stp_bl;
      phase_nxt     = stp_phase;
      acc_nxt       = stp_acc;
      fbr_nxt       = stp_fbr;
      moff_nxt      = stp_moff;
      crem_nxt      = stp_crem;
    end
    if (cmd.copy_wr) begin
      crem_nxt = crem_r - 8'd1;
    end
    if (mem_we) begin
      pos_nxt  = pos_r + 24'd1;
      wptr_nxt = wptr_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= '0;
      pos_r       <= '0;
      wptr_r      <= '0;
      bits_left_r <= '0;
      phase_r     <= lzpd_pkg::PH_FLAG;
      acc_r       <= '0;
      fbr_r       <= '0;
      moff_r      <= '0;
      crem_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      size_r      <= size_nxt;
      pos_r       <= pos_nxt;
      wptr_r      <= wptr_nxt;
      bits_left_r <= bits_left_nxt;
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      fbr_r       <= fbr_nxt;
      moff_r      <= moff_nxt;
      crem_r      <= crem_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bit_byte_r <= bit_byte_nxt;
    if (cmd.copy_rd) begin
      src_ok_r <= (moff_r != 14'd0) && (24'(moff_r) <= pos_r);
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_byte_r   <= (cmd.out_status == lzpd_pkg::ST_BYTE) ? put_val : 8'd0;
    end
  end

  // history memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wptr_r] <= put_val;
    end
    if (cmd.copy_rd) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign stat.pos_done  = pos_r >= size_r;
  assign stat.copy_pend = crem_r != 8'd0;
  assign stat.size_zero = size_r == '0;
  assign stat.push_busy = bits_left_r != 4'd0;
  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.bit_evt   = evt;

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_status = out_status_r;

endmodule

/* hdl/lzpd_ctrl.sv */
// controller: sequences one item at a time and issues datapath commands
module lzpd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_op,
  output logic                  in_ready,
  input  lzpd_pkg::dp_stat_t    stat,
  output lzpd_pkg::dp_cmd_t     cmd,
  output lzpd_pkg::ctrl_state_t state
);

  lzpd_pkg::ctrl_state_t state_r, state_nxt;
  lzpd_pkg::op_t         op;
  logic                  fire;

  assign op   = lzpd_pkg::op_t'(in_op);
  assign fire = in_valid && stat.out_free && (state_r == lzpd_pkg::CS_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lzpd_pkg::CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lzpd_pkg::CS_IDLE: begin
        if (fire && (op == lzpd_pkg::OP_PULL) && !stat.pos_done) begin
          state_nxt = stat.copy_pend ? lzpd_pkg::CS_CP_RD : lzpd_pkg::CS_BIT;
        end
      end
      lzpd_pkg::CS_BIT: begin
        if (stat.bit_evt == lzpd_pkg::EV_COPY) begin
          state_nxt = lzpd_pkg::CS_CP_RD;
        end else if (stat.bit_evt != lzpd_pkg::EV_CONT) begin
          state_nxt = lzpd_pkg::CS_IDLE;
        end
      end
      lzpd_pkg::CS_CP_RD: state_nxt = lzpd_pkg::CS_CP_WR;
      lzpd_pkg::CS_CP_WR: state_nxt = lzpd_pkg::CS_IDLE;
      default:            state_nxt = lzpd_pkg::CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      lzpd_pkg::CS_IDLE: begin
        in_ready = stat.out_free;
        if (fire) begin
          unique case (op)
            lzpd_pkg::OP_START: begin
              cmd.start      = 1'b1;
              cmd.out_load   = 1'b1;
              cmd.out_status = stat.size_zero ? lzpd_pkg::ST_DONE : lzpd_pkg::ST_NEED;
            end
            lzpd_pkg::OP_PUSH: begin
              cmd.out_load = 1'b1;
              if (stat.push_busy) begin
                cmd.out_status = lzpd_pkg::ST_PUSH_REJ;
              end else begin
                cmd.push       = 1'b1;
                cmd.out_status = lzpd_pkg::ST_PUSH_OK;
              end
            end
            lzpd_pkg::OP_PULL: begin
              if (stat.pos_done) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = lzpd_pkg::ST_DONE;
              end
            end
            lzpd_pkg::OP_NONE: begin
              cmd.out_load   = 1'b1;
              cmd.out_status = lzpd_pkg::ST_PUSH_REJ;
            end
            default: cmd.out_status = lzpd_pkg::ST_PUSH_REJ;
          endcase
        end
      end
      lzpd_pkg::CS_BIT: begin
        cmd.bit_step = 1'b1;
        if (stat.bit_evt == lzpd_pkg::EV_NEED) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = lzpd_pkg::ST_NEED;
        end else if (stat.bit_evt == lzpd_pkg::EV_LIT) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = lzpd_pkg::ST_BYTE;
        end
      end
      lzpd_pkg::CS_CP_RD: cmd.copy_rd = 1'b1;
      lzpd_pkg::CS_CP_WR: begin
        cmd.copy_wr    = 1'b1;
        cmd.out_load   = 1'b1;
        cmd.out_status = lzpd_pkg::ST_BYTE;
      end
      default: cmd = '0;
    endcase
  end

  assign state = state_r;

endmodule

/* hdl/lz_position_width_decompressor_top.sv */
// top level of the lz position-width decompressor
// start, push, unused codes and pull past the end are answered from the idle state; a pull
// with a pending copy does a history read, then the copy write; a pull that decodes steps the
// one-bit-per-cycle reader through up to 8 bits until a literal, a copy or an empty reader,
// then a copy uses the registered history read port; one item at a time, taken when idle and output free
// reset: synchronous active-low, clears all control state; history is not cleared
module lz_position_width_decompressor_top #(
  parameter int WINDOW_DEPTH = lzpd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lzpd_pkg::SIZE_W-1:0] cfg_wdata,
  lzpd_in_if.sink                     in_ch,
  lzpd_out_if.source                  out_ch
);

  // command and status between controller and datapath
  lzpd_pkg::dp_cmd_t     cmd;
  lzpd_pkg::dp_stat_t    stat;
  lzpd_pkg::ctrl_state_t state;
  lzpd_pkg::status_t     out_status;

  // controller: one item in flight, result goes to the output register
  lzpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.operation),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd),
    .state    (state)
  );

  // datapath: bit reader, token decode, history and output register
  lzpd_dpath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_data_byte (in_ch.data_byte),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_byte     (out_ch.out_byte),
    .out_status   (out_status)
  );

  // status code straight from the output register
  assign out_ch.status = out_status;

`ifndef ASSERT_OFF
  // the output register is only loaded when it is empty or being drained
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded over an untaken item");

  // a history read is always followed by the copy write and a byte item
  a_copy_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.copy_rd |=> (cmd.copy_wr && cmd.out_load && (cmd.out_status == lzpd_pkg::ST_BYTE)))
    else $error("copy read not followed by write");

  // running out of bits ends the pull with a result waiting
  a_need_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state == lzpd_pkg::CS_BIT) && (stat.bit_evt == lzpd_pkg::EV_NEED))
      |=> ((state == lzpd_pkg::CS_IDLE) && out_ch.valid))
    else $error("empty bit reader did not end the pull");
`endif

endmodule
